// ----- src/pfc_pkg.sv -----
// Shared types, constants and helpers for the PFC buffer admission and accounting core.
package pfc_pkg;

  localparam int unsigned PortsDefault      = 32;
  localparam int unsigned DataQueuesDefault = 8;
  localparam logic [31:0] TotalBufferReset  = 32'(12 * 1024 * 1024);
  localparam int unsigned CfgIndexW         = 3;
  localparam int unsigned CfgDataW          = 32;

  typedef enum logic [2:0] {
    OP_CHECK   = 3'd0,
    OP_IN_ADD  = 3'd1,
    OP_IN_REM  = 3'd2,
    OP_EG_ADD  = 3'd3,
    OP_EG_REM  = 3'd4,
    OP_PAUSE   = 3'd5,
    OP_RESUME  = 3'd6,
    OP_QUERY   = 3'd7
  } opcode_e;

  typedef enum logic [CfgIndexW-1:0] {
    CFG_TOTAL_BUFFER = 3'd0,
    CFG_HEADROOM     = 3'd1,
    CFG_RESERVE      = 3'd2,
    CFG_RESUME_OFF   = 3'd3,
    CFG_ECN_KMIN     = 3'd4,
    CFG_ECN_KMAX     = 3'd5,
    CFG_ECN_PMAX     = 3'd6,
    CFG_ECN_ENABLE   = 3'd7
  } cfg_index_e;

  // One queue's accounting entry as held in the memory
  typedef struct packed {
    logic        paused;
    logic [31:0] egress;
    logic [31:0] headroom;
    logic [31:0] ingress;
  } entry_t;

  // Controller to datapath commands
  typedef struct packed {
    logic clr_we;
    logic capture;
    logic rd;
    logic calc;
    logic upd;
    logic mul;
    logic fin;
  } cmd_t;

  function automatic logic [31:0] sat_add32(input logic [31:0] a, input logic [32:0] b);
    logic [33:0] s;
    s = {2'b00, a} + {1'b0, b};
    return (s > 34'hFFFF_FFFF) ? 32'hFFFF_FFFF : s[31:0];
  endfunction

endpackage

// ----- src/pfc_ctrl.sv -----
// Controller FSM: clearing pass after reset and sequencing of one request.
module pfc_ctrl #(
  parameter int unsigned AW = 9,
  parameter int unsigned NQ = 288
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  output pfc_pkg::cmd_t  cmd_o,
  output logic [AW-1:0]  clr_addr_o
);
  import pfc_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_READ, S_CALC, S_UPD, S_MUL, S_OUT
  } state_e;

  state_e        state_q, state_d;
  logic [AW-1:0] clr_q, clr_d;

  always_comb begin
    state_d = state_q;
    clr_d   = clr_q;
    cmd_o   = '0;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.clr_we = 1'b1;
        if (clr_q == AW'(NQ - 1)) begin
          state_d = S_IDLE;
        end else begin
          clr_d = clr_q + 1'b1;
        end
      end
      S_IDLE: begin
        cmd_o.capture = start;
        if (start) state_d = S_READ;
      end
      S_READ: begin
        cmd_o.rd = 1'b1;
        state_d  = S_CALC;
      end
      S_CALC: begin
        cmd_o.calc = 1'b1;
        state_d    = S_UPD;
      end
      S_UPD: begin
        cmd_o.upd = 1'b1;
        state_d   = S_MUL;
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = S_OUT;
      end
      S_OUT: begin
        cmd_o.fin = 1'b1;
        state_d   = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
    end
  end

  assign busy       = (state_q != S_IDLE);
  assign clr_addr_o = clr_q;

endmodule

// ----- src/pfc_datapath.sv -----
// Datapath: configuration registers, queue memory, accounting and ECN arithmetic.
module pfc_datapath #(
  parameter int unsigned PORTS       = pfc_pkg::PortsDefault,
  parameter int unsigned DATA_QUEUES = pfc_pkg::DataQueuesDefault,
  parameter int unsigned AW          = 9
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  pfc_pkg::cmd_t                  cmd_i,
  input  logic [AW-1:0]                  clr_addr_i,
  input  logic                           cfg_we_i,
  input  logic [pfc_pkg::CfgIndexW-1:0]  cfg_index_i,
  input  logic [pfc_pkg::CfgDataW-1:0]   cfg_wdata_i,
  input  logic [2:0]                     opcode_i,
  input  logic [4:0]                     port_index_i,
  input  logic [3:0]                     queue_index_i,
  input  logic [15:0]                    packet_bytes_i,
  input  logic [15:0]                    random_value_i,
  output logic                           result_valid_o,
  output logic                           admit_o,
  output logic                           send_pause_o,
  output logic                           send_resume_o,
  output logic                           ecn_mark_o,
  output logic [31:0]                    ingress_bytes_o,
  output logic [31:0]                    headroom_bytes_o,
  output logic [31:0]                    egress_bytes_o,
  output logic [31:0]                    shared_used_total_o,
  output logic                           underflow_o
);
  import pfc_pkg::*;

  localparam int unsigned QPP = DATA_QUEUES + 1;
  localparam int unsigned NQ  = PORTS * QPP;
  localparam int unsigned NW  = $clog2(NQ + 1);
  localparam int unsigned PW  = 25 + NW;
  localparam int unsigned CW  = (PW > 32) ? PW : 32;

  // configuration
  logic [31:0] total_q, kmin_q, kmax_q;
  logic [23:0] hpq_q, res_q, roff_q;
  logic [15:0] pmax_q;
  logic        en_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= TotalBufferReset;
      hpq_q   <= '0;
      res_q   <= '0;
      roff_q  <= '0;
      kmin_q  <= '0;
      kmax_q  <= '0;
      pmax_q  <= '0;
      en_q    <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_e'(cfg_index_i))
        CFG_TOTAL_BUFFER: total_q <= cfg_wdata_i;
        CFG_HEADROOM:     hpq_q   <= cfg_wdata_i[23:0];
        CFG_RESERVE:      res_q   <= cfg_wdata_i[23:0];
        CFG_RESUME_OFF:   roff_q  <= cfg_wdata_i[23:0];
        CFG_ECN_KMIN:     kmin_q  <= cfg_wdata_i;
        CFG_ECN_KMAX:     kmax_q  <= cfg_wdata_i;
        CFG_ECN_PMAX:     pmax_q  <= cfg_wdata_i[15:0];
        CFG_ECN_ENABLE:   en_q    <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // shared pool size, recomputed continuously from configuration
  logic [PW-1:0] carve_q;
  logic [31:0]   ssize_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      carve_q <= '0;
      ssize_q <= '0;
    end else begin
      carve_q <= PW'(NW'(NQ)) * PW'({1'b0, hpq_q} + {1'b0, res_q});
      ssize_q <= (CW'(total_q) > CW'(carve_q)) ? 32'(CW'(total_q) - CW'(carve_q)) : '0;
    end
  end

  // request capture
  opcode_e       op_q;
  logic [AW-1:0] addr_q;
  logic          inr_q, dq_q;
  logic [15:0]   size_q, rnd_q;
  logic [31:0]   shared_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q   <= opcode_e'(opcode_i);
      addr_q <= AW'(32'(port_index_i) * QPP + 32'(queue_index_i));
      inr_q  <= (32'(port_index_i) < PORTS) && (32'(queue_index_i) <= DATA_QUEUES);
      dq_q   <= (32'(queue_index_i) < DATA_QUEUES);
      size_q <= packet_bytes_i;
      rnd_q  <= random_value_i;
    end
  end

  // queue memory
  entry_t mem [NQ];
  entry_t rd_q;
  entry_t new_q;
  logic   mem_we;
  logic [AW-1:0] mem_wa;
  entry_t mem_wd;

  assign mem_we = cmd_i.clr_we || (cmd_i.upd && inr_q);
  assign mem_wa = cmd_i.clr_we ? clr_addr_i : addr_q;
  assign mem_wd = cmd_i.clr_we ? '0 : new_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    if (cmd_i.rd) rd_q <= mem[addr_q];
  end

  // accounting step
  logic [31:0] ing_old_q;
  logic        admit_q, under_q;
  entry_t      new_d;
  logic        admit_d, under_d;
  logic [32:0] n_sum, n_res;
  logic [31:0] fh, rest;

  always_comb begin
    new_d   = rd_q;
    under_d = 1'b0;
    admit_d = !((33'(size_q) + 33'(shared_q) > 33'(ssize_q)) &&
                (33'(size_q) + 33'(rd_q.headroom) > 33'(hpq_q)));
    n_sum   = 33'(rd_q.ingress) + 33'(size_q);
    n_res   = n_sum - 33'(res_q);
    fh      = (rd_q.headroom < 32'(size_q)) ? rd_q.headroom : 32'(size_q);
    rest    = 32'(size_q) - fh;
    case (op_q)
      OP_IN_ADD: begin
        if (n_sum > 33'(res_q) && n_res > 33'(ssize_q)) begin
          new_d.headroom = sat_add32(rd_q.headroom, 33'(size_q));
        end else begin
          new_d.ingress = sat_add32(rd_q.ingress, 33'(size_q));
        end
      end
      OP_IN_REM: begin
        new_d.headroom = rd_q.headroom - fh;
        if (rest > rd_q.ingress) begin
          under_d       = 1'b1;
          new_d.ingress = '0;
        end else begin
          new_d.ingress = rd_q.ingress - rest;
        end
      end
      OP_EG_ADD: new_d.egress = sat_add32(rd_q.egress, 33'(size_q));
      OP_EG_REM: begin
        if (32'(size_q) > rd_q.egress) begin
          under_d      = 1'b1;
          new_d.egress = '0;
        end else begin
          new_d.egress = rd_q.egress - 32'(size_q);
        end
      end
      OP_PAUSE:  new_d.paused = 1'b1;
      OP_RESUME: new_d.paused = 1'b0;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.calc) begin
      new_q     <= new_d;
      ing_old_q <= rd_q.ingress;
      admit_q   <= admit_d;
      under_q   <= under_d;
    end
  end

  // shared total update and ECN operands
  logic [31:0] sh_before, sh_after, sh_diff, shared_d;
  logic [31:0] dk_q, dl_q;
  logic        gt_kmax_q, gt_kmin_q;

  always_comb begin
    sh_before = (ing_old_q > 32'(res_q)) ? ing_old_q - 32'(res_q) : '0;
    sh_after  = (new_q.ingress > 32'(res_q)) ? new_q.ingress - 32'(res_q) : '0;
    if (sh_after >= sh_before) begin
      sh_diff  = sh_after - sh_before;
      shared_d = sat_add32(shared_q, 33'(sh_diff));
    end else begin
      sh_diff  = sh_before - sh_after;
      shared_d = (shared_q > sh_diff) ? shared_q - sh_diff : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shared_q <= '0;
    end else if (cmd_i.upd && inr_q) begin
      shared_q <= shared_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.upd) begin
      dk_q      <= kmax_q - kmin_q;
      dl_q      <= new_q.egress - kmin_q;
      gt_kmax_q <= new_q.egress > kmax_q;
      gt_kmin_q <= new_q.egress > kmin_q;
    end
  end

  // products and PFC flags
  logic [47:0] p_rnd_q, p_len_q;
  logic        pause_q, resume_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul) begin
      p_rnd_q  <= 48'(rnd_q) * 48'(dk_q);
      p_len_q  <= 48'(pmax_q) * 48'(dl_q);
      pause_q  <= !new_q.paused && (new_q.headroom != '0);
      resume_q <= new_q.paused && (new_q.headroom == '0) &&
                  ((new_q.ingress <= 32'(res_q)) ||
                   (33'(shared_q) + 33'(roff_q) <= 33'(ssize_q)));
    end
  end

  // result register
  logic mark;
  assign mark = dq_q && en_q && (gt_kmax_q || (gt_kmin_q && (p_rnd_q < p_len_q)));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      result_valid_o <= 1'b0;
    end else begin
      result_valid_o <= cmd_i.fin;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.fin) begin
      admit_o             <= inr_q && admit_q;
      send_pause_o        <= inr_q && pause_q;
      send_resume_o       <= inr_q && resume_q;
      ecn_mark_o          <= inr_q && mark;
      underflow_o         <= inr_q && under_q;
      ingress_bytes_o     <= inr_q ? new_q.ingress  : '0;
      headroom_bytes_o    <= inr_q ? new_q.headroom : '0;
      egress_bytes_o      <= inr_q ? new_q.egress   : '0;
      shared_used_total_o <= shared_q;
    end
  end

endmodule

// ----- src/pfc_buffer_admission_accounting_core.sv -----
// Top level of the PFC shared-buffer admission and accounting core.
// Usage:
//   A request (opcode, port, queue, packet size, random word) is taken at a
//   rising edge where start is high and busy is low. One result per request
//   appears on the result ports for exactly one cycle, flagged by
//   result_valid_o; the receiver cannot hold it off.
//   After the accepting edge the request steps through the read, calc,
//   update, multiply and output states; the result is then shown, and busy
//   drops together with it, so a new request is taken only after the last
//   result is shown. This sequence is set by the read-modify-write of the
//   queue memory and the ECN multiply stage that follows it.
//   Configuration writes (cfg_we_i, cfg_index_i, cfg_wdata_i) take effect at
//   once and belong only in idle periods; the shared pool size is settled
//   in time for a request taken at the next edge.
//   Reset: the configuration registers return to their defaults, then a
//   clearing pass zeroes the PORTS*(DATA_QUEUES+1) queue entries, one per
//   cycle, with busy high. Requests to a port or queue out of range change
//   nothing and report only the shared total.
module pfc_buffer_admission_accounting_core #(
  parameter int unsigned PORTS       = pfc_pkg::PortsDefault,
  parameter int unsigned DATA_QUEUES = pfc_pkg::DataQueuesDefault
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [pfc_pkg::CfgIndexW-1:0]  cfg_index_i,
  input  logic [pfc_pkg::CfgDataW-1:0]   cfg_wdata_i,
  input  logic                           start,
  output logic                           busy,
  input  logic [2:0]                     opcode_i,
  input  logic [4:0]                     port_index_i,
  input  logic [3:0]                     queue_index_i,
  input  logic [15:0]                    packet_bytes_i,
  input  logic [15:0]                    random_value_i,
  output logic                           result_valid_o,
  output logic                           admit_o,
  output logic                           send_pause_o,
  output logic                           send_resume_o,
  output logic                           ecn_mark_o,
  output logic [31:0]                    ingress_bytes_o,
  output logic [31:0]                    headroom_bytes_o,
  output logic [31:0]                    egress_bytes_o,
  output logic [31:0]                    shared_used_total_o,
  output logic                           underflow_o
);
  import pfc_pkg::*;

  localparam int unsigned NQ = PORTS * (DATA_QUEUES + 1);
  localparam int unsigned AW = $clog2(NQ);

  cmd_t          cmd;
  logic [AW-1:0] clr_addr;

  pfc_ctrl #(.AW(AW), .NQ(NQ)) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .cmd_o      (cmd),
    .clr_addr_o (clr_addr)
  );

  pfc_datapath #(.PORTS(PORTS), .DATA_QUEUES(DATA_QUEUES), .AW(AW)) u_dp (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (cmd),
    .clr_addr_i          (clr_addr),
    .cfg_we_i            (cfg_we_i),
    .cfg_index_i         (cfg_index_i),
    .cfg_wdata_i         (cfg_wdata_i),
    .opcode_i            (opcode_i),
    .port_index_i        (port_index_i),
    .queue_index_i       (queue_index_i),
    .packet_bytes_i      (packet_bytes_i),
    .random_value_i      (random_value_i),
    .result_valid_o      (result_valid_o),
    .admit_o             (admit_o),
    .send_pause_o        (send_pause_o),
    .send_resume_o       (send_resume_o),
    .ecn_mark_o          (ecn_mark_o),
    .ingress_bytes_o     (ingress_bytes_o),
    .headroom_bytes_o    (headroom_bytes_o),
    .egress_bytes_o      (egress_bytes_o),
    .shared_used_total_o (shared_used_total_o),
    .underflow_o         (underflow_o)
  );

endmodule

// ----- sim/pfc_admission_checker.sv -----
// Checker for the PFC admission core: predicts each request's result and compares it.
module pfc_admission_checker
  import pfc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        start_i,
  input  logic        busy_i,
  input  logic [2:0]  opcode_i,
  input  logic [4:0]  port_index_i,
  input  logic [3:0]  queue_index_i,
  input  logic [15:0] packet_bytes_i,
  input  logic [15:0] random_value_i,
  input  logic        result_valid_i,
  input  logic        admit_i,
  input  logic        send_pause_i,
  input  logic        send_resume_i,
  input  logic        ecn_mark_i,
  input  logic [31:0] ingress_bytes_i,
  input  logic [31:0] headroom_bytes_i,
  input  logic [31:0] egress_bytes_i,
  input  logic [31:0] shared_used_total_i,
  input  logic        underflow_i,
  output int          fail_count_o,
  output int          pending_o,
  output int          checked_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NumPorts = PortsDefault;
  localparam int DataQ    = DataQueuesDefault;
  localparam int NumQ     = NumPorts * (DataQ + 1);
  localparam logic [63:0] Max32 = 64'hFFFF_FFFF;

  typedef struct packed {
    logic        admit;
    logic        pause;
    logic        resume;
    logic        mark;
    logic [31:0] ingress;
    logic [31:0] headroom;
    logic [31:0] egress;
    logic [31:0] shared;
    logic        under;
  } outcome_t;

  logic [31:0] total_buf, hr_per_q, res_per_q, resume_off, kmin, kmax, pmax;
  logic        ecn_en;
  logic [31:0] ing_used [NumQ];
  logic [31:0] hr_used  [NumQ];
  logic [31:0] eg_used  [NumQ];
  logic        paused   [NumQ];
  logic [31:0] shared_tot;
  outcome_t    outcome_q[$];

  function automatic logic [31:0] sat32(logic [63:0] s);
    return (s > Max32) ? Max32[31:0] : s[31:0];
  endfunction

  function automatic logic [63:0] pool_size();
    logic [63:0] carve;
    carve = 64'(NumQ) * (64'(hr_per_q) + 64'(res_per_q));
    return (64'(total_buf) > carve) ? 64'(total_buf) - carve : 64'd0;
  endfunction

  function automatic logic [63:0] beyond_reserve(logic [31:0] ing);
    return (ing > res_per_q) ? 64'(ing) - 64'(res_per_q) : 64'd0;
  endfunction

  task automatic write_ingress(int q, logic [31:0] v);
    logic [63:0] was, now;
    was = beyond_reserve(ing_used[q]);
    now = beyond_reserve(v);
    ing_used[q] = v;
    if (now >= was) shared_tot = sat32(64'(shared_tot) + (now - was));
    else if (64'(shared_tot) > (was - now)) shared_tot = shared_tot - 32'(was - now);
    else shared_tot = '0;
  endtask

  task automatic account_request(input opcode_e op, input int port, input int qi,
                                 input logic [63:0] size, input logic [63:0] rnd,
                                 output outcome_t o);
    logic [63:0] pool, n, fh, rest, len;
    int q;
    pool = pool_size();
    o = '0;
    if (port >= NumPorts || qi > DataQ) begin
      o.shared = shared_tot;
      return;
    end
    q = port * (DataQ + 1) + qi;
    o.admit = !((size + shared_tot > pool) && (size + hr_used[q] > hr_per_q));
    case (op)
      OP_IN_ADD: begin
        n = 64'(ing_used[q]) + size;
        if (n > res_per_q && n - res_per_q > pool) hr_used[q] = sat32(64'(hr_used[q]) + size);
        else write_ingress(q, sat32(n));
      end
      OP_IN_REM: begin
        fh = (hr_used[q] < size) ? 64'(hr_used[q]) : size;
        rest = size - fh;
        hr_used[q] = hr_used[q] - 32'(fh);
        if (rest > ing_used[q]) begin
          o.under = 1'b1;
          write_ingress(q, '0);
        end else write_ingress(q, ing_used[q] - 32'(rest));
      end
      OP_EG_ADD: eg_used[q] = sat32(64'(eg_used[q]) + size);
      OP_EG_REM: begin
        if (size > eg_used[q]) begin
          o.under = 1'b1;
          eg_used[q] = '0;
        end else eg_used[q] = eg_used[q] - 32'(size);
      end
      OP_PAUSE:  paused[q] = 1'b1;
      OP_RESUME: paused[q] = 1'b0;
      default: ;
    endcase
    o.pause  = !paused[q] && hr_used[q] != 0;
    o.resume = paused[q] && hr_used[q] == 0 &&
               (beyond_reserve(ing_used[q]) == 0 || 64'(shared_tot) + resume_off <= pool);
    if (qi < DataQ && ecn_en) begin
      len = eg_used[q];
      if (len > kmax) o.mark = 1'b1;
      else if (len > kmin)
        o.mark = rnd * (64'(kmax) - 64'(kmin)) < 64'(pmax) * (len - 64'(kmin));
    end
    o.ingress  = ing_used[q];
    o.headroom = hr_used[q];
    o.egress   = eg_used[q];
    o.shared   = shared_tot;
  endtask

  task automatic compare_field(string name, logic [31:0] exp, logic [31:0] act);
    if (exp !== act) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $realtime, name, exp, act);
      fail_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    outcome_t o, e;
    if (!rst_ni) begin
      total_buf  <= TotalBufferReset;
      hr_per_q   <= '0;
      res_per_q  <= '0;
      resume_off <= '0;
      kmin       <= '0;
      kmax       <= '0;
      pmax       <= '0;
      ecn_en     <= 1'b0;
      for (int i = 0; i < NumQ; i++) begin
        ing_used[i] = '0;
        hr_used[i]  = '0;
        eg_used[i]  = '0;
        paused[i]   = 1'b0;
      end
      shared_tot = '0;
      outcome_q.delete();
      fail_count_o = 0;
      pending_o    <= 0;
      checked_o    <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_e'(cfg_index_i))
          CFG_TOTAL_BUFFER: total_buf  <= cfg_wdata_i;
          CFG_HEADROOM:     hr_per_q   <= {8'd0, cfg_wdata_i[23:0]};
          CFG_RESERVE:      res_per_q  <= {8'd0, cfg_wdata_i[23:0]};
          CFG_RESUME_OFF:   resume_off <= {8'd0, cfg_wdata_i[23:0]};
          CFG_ECN_KMIN:     kmin       <= cfg_wdata_i;
          CFG_ECN_KMAX:     kmax       <= cfg_wdata_i;
          CFG_ECN_PMAX:     pmax       <= {16'd0, cfg_wdata_i[15:0]};
          CFG_ECN_ENABLE:   ecn_en     <= cfg_wdata_i[0];
          default: ;
        endcase
      end
      if (start_i && !busy_i) begin
        account_request(opcode_e'(opcode_i), int'(port_index_i), int'(queue_index_i),
                        64'(packet_bytes_i), 64'(random_value_i), o);
        outcome_q = {outcome_q, o};
      end
      if (result_valid_i) begin
        if (outcome_q.size() == 0) begin
          $display("%0t: result with no request outstanding", $realtime);
          fail_count_o++;
        end else begin
          e = outcome_q.pop_front();
          compare_field("admit", 32'(e.admit), 32'(admit_i));
          compare_field("send_pause", 32'(e.pause), 32'(send_pause_i));
          compare_field("send_resume", 32'(e.resume), 32'(send_resume_i));
          compare_field("ecn_mark", 32'(e.mark), 32'(ecn_mark_i));
          compare_field("ingress_bytes", e.ingress, ingress_bytes_i);
          compare_field("headroom_bytes", e.headroom, headroom_bytes_i);
          compare_field("egress_bytes", e.egress, egress_bytes_i);
          compare_field("shared_used_total", e.shared, shared_used_total_i);
          compare_field("underflow", 32'(e.under), 32'(underflow_i));
          checked_o <= checked_o + 1;
        end
      end
      pending_o <= outcome_q.size();
    end
  end

endmodule

// ----- sim/tb.sv -----
// Testbench top for the PFC admission core: stimulus, configuration phases and verdict.
module tb;
  import pfc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit = 400000;
  localparam int RandPerPhase = 205;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_wdata = '0;
  logic        start = 1'b0;
  logic        busy;
  logic [2:0]  opcode = '0;
  logic [4:0]  port_index = '0;
  logic [3:0]  queue_index = '0;
  logic [15:0] packet_bytes = '0;
  logic [15:0] random_value = '0;
  logic        result_valid, admit, send_pause, send_resume, ecn_mark, underflow;
  logic [31:0] ingress_bytes, headroom_bytes, egress_bytes, shared_used_total;
  int          fail_count, pending, checked, cycles = 0, phase_no = 0;

  always #10 clk = ~clk;

  pfc_buffer_admission_accounting_core dut (
    .clk_i(clk), .rst_ni(rst_n), .cfg_we_i(cfg_we), .cfg_index_i(cfg_index),
    .cfg_wdata_i(cfg_wdata), .start(start), .busy(busy), .opcode_i(opcode),
    .port_index_i(port_index), .queue_index_i(queue_index),
    .packet_bytes_i(packet_bytes), .random_value_i(random_value),
    .result_valid_o(result_valid), .admit_o(admit), .send_pause_o(send_pause),
    .send_resume_o(send_resume), .ecn_mark_o(ecn_mark),
    .ingress_bytes_o(ingress_bytes), .headroom_bytes_o(headroom_bytes),
    .egress_bytes_o(egress_bytes), .shared_used_total_o(shared_used_total),
    .underflow_o(underflow)
  );

  pfc_admission_checker chk (
    .clk_i(clk), .rst_ni(rst_n), .cfg_we_i(cfg_we), .cfg_index_i(cfg_index),
    .cfg_wdata_i(cfg_wdata), .start_i(start), .busy_i(busy), .opcode_i(opcode),
    .port_index_i(port_index), .queue_index_i(queue_index),
    .packet_bytes_i(packet_bytes), .random_value_i(random_value),
    .result_valid_i(result_valid), .admit_i(admit), .send_pause_i(send_pause),
    .send_resume_i(send_resume), .ecn_mark_i(ecn_mark),
    .ingress_bytes_i(ingress_bytes), .headroom_bytes_i(headroom_bytes),
    .egress_bytes_i(egress_bytes), .shared_used_total_i(shared_used_total),
    .underflow_i(underflow), .fail_count_o(fail_count), .pending_o(pending),
    .checked_o(checked)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Timeout after %0d cycles", cycles);
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    if (phase_no == 3) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // start stays high into the next request when the gap is zero
  task automatic send_request(opcode_e op, logic [4:0] p, logic [3:0] q,
                              logic [15:0] sz, logic [15:0] rnd);
    int gap;
    gap = pick_gap();
    opcode       <= op;
    port_index   <= p;
    queue_index  <= q;
    packet_bytes <= sz;
    random_value <= rnd;
    start        <= 1'b1;
    do @(negedge clk); while (busy);
    @(posedge clk);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (10) @(posedge clk);
  endtask

  task automatic configure(logic [31:0] tb_v, logic [31:0] hr, logic [31:0] res,
                           logic [31:0] roff, logic [31:0] kn, logic [31:0] kx,
                           logic [31:0] pm, logic [31:0] en);
    logic [31:0] vals [8];
    vals = '{tb_v, hr, res, roff, kn, kx, pm, en};
    for (int i = 0; i < 8; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= 3'(i);
      cfg_wdata <= vals[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    repeat (8) @(posedge clk);
  endtask

  task automatic random_requests(int count);
    opcode_e op;
    int r;
    logic [4:0]  p;
    logic [3:0]  q;
    logic [15:0] sz;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      if (r < 30) op = OP_IN_ADD;
      else if (r < 45) op = OP_IN_REM;
      else if (r < 60) op = OP_EG_ADD;
      else if (r < 70) op = OP_EG_REM;
      else op = opcode_e'($urandom_range(0, 7));
      p  = ($urandom_range(0, 99) < 80) ? 5'($urandom_range(0, 3)) : 5'($urandom);
      q  = ($urandom_range(0, 99) < 92) ? 4'($urandom_range(0, 8)) : 4'($urandom);
      sz = ($urandom_range(0, 99) < 70) ? 16'($urandom_range(0, 4000)) : 16'($urandom);
      send_request(op, p, q, sz, 16'($urandom));
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // defaults after reset: large pool, ECN off
    send_request(OP_CHECK, 5'd0, 4'd0, 16'hFFFF, 16'd0);
    send_request(OP_IN_ADD, 5'd0, 4'd0, 16'd0, 16'd0);
    send_request(OP_IN_ADD, 5'd0, 4'd0, 16'hFFFF, 16'hFFFF);
    send_request(OP_IN_REM, 5'd0, 4'd0, 16'd100, 16'd0);
    send_request(OP_IN_REM, 5'd0, 4'd1, 16'd1, 16'd0);
    send_request(OP_EG_ADD, 5'd31, 4'd8, 16'hFFFF, 16'd0);
    send_request(OP_EG_REM, 5'd31, 4'd8, 16'd1, 16'd0);
    send_request(OP_EG_REM, 5'd31, 4'd7, 16'hFFFF, 16'd0);
    send_request(OP_PAUSE, 5'd1, 4'd2, 16'd0, 16'd0);
    send_request(OP_QUERY, 5'd1, 4'd2, 16'd0, 16'd0);
    send_request(OP_RESUME, 5'd1, 4'd2, 16'd0, 16'd0);
    send_request(OP_IN_ADD, 5'd3, 4'd9, 16'd500, 16'd0);
    send_request(OP_QUERY, 5'd3, 4'd15, 16'd0, 16'd0);
    random_requests(RandPerPhase);
    drain();

    // tight pool so headroom, pause/resume and ECN come into play
    phase_no = 1;
    configure(32'd884000, 32'd2000, 32'd1000, 32'd5000, 32'd1000, 32'd50000,
              32'h8000, 32'd1);
    send_request(OP_IN_ADD, 5'd2, 4'd3, 16'd30000, 16'd0);
    send_request(OP_IN_ADD, 5'd2, 4'd3, 16'd30000, 16'd0);
    send_request(OP_CHECK, 5'd2, 4'd3, 16'd1500, 16'd0);
    send_request(OP_PAUSE, 5'd2, 4'd3, 16'd0, 16'd0);
    send_request(OP_IN_REM, 5'd2, 4'd3, 16'd40000, 16'd0);
    send_request(OP_EG_ADD, 5'd2, 4'd3, 16'd20000, 16'h0001);
    send_request(OP_EG_ADD, 5'd2, 4'd3, 16'd40000, 16'hFFFF);
    send_request(OP_EG_ADD, 5'd2, 4'd8, 16'd40000, 16'd0);
    random_requests(RandPerPhase);
    drain();

    // extremes: no shared pool, widest carve-outs and thresholds
    phase_no = 2;
    configure(32'd0, 32'hFFFFFF, 32'hFFFFFF, 32'hFFFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
              32'hFFFF, 32'd1);
    random_requests(RandPerPhase);
    drain();

    // full-size pool, no reserve, widest ECN ramp, back-to-back requests
    phase_no = 3;
    configure(32'hFFFF_FFFF, 32'd0, 32'd0, 32'd0, 32'd0, 32'hFFFF_FFFF, 32'hFFFF, 32'd1);
    random_requests(RandPerPhase);
    drain();

    $display("Checked %0d results over four buffer settings, from defaults to extremes,",
             checked);
    $display("with headroom, pause/resume, ECN and underflow paths exercised.");
    if (fail_count == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule

// ----- sim.f -----
src/pfc_pkg.sv
src/pfc_ctrl.sv
src/pfc_datapath.sv
src/pfc_buffer_admission_accounting_core.sv
sim/pfc_admission_checker.sv
sim/tb.sv
